>>> rtl/core/pwbt_pkg.sv
package pwbt_pkg;

	localparam int unsigned CFG_W            = 12;
	localparam int unsigned CFG_IDX_W        = 2;
	localparam int unsigned DATA_W           = 8;
	localparam int unsigned BITS_PER_FRAME_D = 8;
	localparam int unsigned TICK_CNT_W_D     = 12;

	localparam logic [CFG_W-1:0] START_HIGH_RST = CFG_W'(1000);
	localparam logic [CFG_W-1:0] START_LOW_RST  = CFG_W'(3200);
	localparam logic [CFG_W-1:0] LONG_RST       = CFG_W'(600);
	localparam logic [CFG_W-1:0] SHORT_RST      = CFG_W'(200);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_HIGH = 2'd0,
		REG_START_LOW  = 2'd1,
		REG_LONG       = 2'd2,
		REG_SHORT      = 2'd3
	} reg_idx_t;

	typedef enum logic {
		CMD_TICK = 1'b0,
		CMD_SEND = 1'b1
	} cmd_t;

	typedef struct packed {
		logic              command;
		logic [DATA_W-1:0] data_byte;
	} item_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic rejected;
		logic frame_done;
	} result_t;

endpackage

>>> rtl/core/pulse_width_byte_transmitter.sv
// Each accepted item yields a result beat, registered into the output register or, while it is stalled, the skid entry.
// Throughput: one item per cycle while the skid entry is empty; a two-deep output
// buffer takes one more item during a downstream stall, then holds cmd_ready low.
// Reset (arst_n, async, active low): idle, line high, timing registers at
// their default lengths, output buffer empty.
module pulse_width_byte_transmitter #(
	parameter int unsigned BITS_PER_FRAME   = pwbt_pkg::BITS_PER_FRAME_D,
	parameter int unsigned TICK_COUNT_WIDTH = pwbt_pkg::TICK_CNT_W_D
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cmd_valid,
	output logic                             cmd_ready,
	input  pwbt_pkg::item_t                  cmd,
	output logic                             res_valid,
	input  logic                             res_ready,
	output pwbt_pkg::result_t                res,
	input  logic                             cfg_we,
	input  logic [pwbt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pwbt_pkg::CFG_W-1:0]       cfg_data
);

	localparam int unsigned CW = pwbt_pkg::CFG_W;
	localparam int unsigned TW = TICK_COUNT_WIDTH;
	localparam int unsigned LW = ((TW > CW) ? TW : CW) + 1;
	localparam int unsigned BW = $clog2(BITS_PER_FRAME + 1);
	localparam logic [LW-1:0] CNT_MAX = {{(LW-TW){1'b0}}, {TW{1'b1}}};

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_START_HI,
		PH_START_LO,
		PH_BIT_HI,
		PH_BIT_LO
	} phase_t;

	logic [CW-1:0] start_high_q, start_low_q, long_q, short_q;

	phase_t                        phase_q, phase_d;
	logic [TW-1:0]                 tick_q, tick_d;
	logic [BW-1:0]                 bit_q, bit_d;
	logic [pwbt_pkg::DATA_W-1:0]   shift_q, shift_d;
	logic                          line_q, line_d;
	logic                          rejected_d, done_d;

	logic [CW-1:0] sel_len;
	logic [LW-1:0] len, spent;
	logic [BW:0]   bit_next;
	logic          accept;

	pwbt_pkg::result_t result_d, skid_s1;
	logic              skid_valid_q;

	assign cmd_ready = !skid_valid_q;
	assign accept    = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_high_q <= pwbt_pkg::START_HIGH_RST;
			start_low_q  <= pwbt_pkg::START_LOW_RST;
			long_q       <= pwbt_pkg::LONG_RST;
			short_q      <= pwbt_pkg::SHORT_RST;
		end else if (cfg_we) begin
			case (pwbt_pkg::reg_idx_t'(cfg_index))
				pwbt_pkg::REG_START_HIGH: start_high_q <= cfg_data;
				pwbt_pkg::REG_START_LOW:  start_low_q  <= cfg_data;
				pwbt_pkg::REG_LONG:       long_q       <= cfg_data;
				pwbt_pkg::REG_SHORT:      short_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (phase_q)
			PH_START_HI: sel_len = start_high_q;
			PH_START_LO: sel_len = start_low_q;
			PH_BIT_HI:   sel_len = shift_q[0] ? long_q : short_q;
			PH_BIT_LO:   sel_len = shift_q[0] ? short_q : long_q;
			default:     sel_len = CW'(1);
		endcase
	end

	// zero acts as one; lengths above the counter range saturate
	always_comb begin
		if (sel_len == '0) begin
			len = LW'(1);
		end else if (LW'(sel_len) > CNT_MAX) begin
			len = CNT_MAX;
		end else begin
			len = LW'(sel_len);
		end
	end

	assign spent    = LW'(tick_q) + LW'(1);
	assign bit_next = {1'b0, bit_q} + (BW+1)'(1);

	always_comb begin
		phase_d    = phase_q;
		tick_d     = tick_q;
		bit_d      = bit_q;
		shift_d    = shift_q;
		line_d     = line_q;
		rejected_d = 1'b0;
		done_d     = 1'b0;
		if (cmd.command == pwbt_pkg::CMD_SEND) begin
			if (phase_q == PH_IDLE) begin
				shift_d = cmd.data_byte;
				bit_d   = '0;
				tick_d  = '0;
				line_d  = 1'b1;
				phase_d = PH_START_HI;
			end else begin
				rejected_d = 1'b1;
			end
		end else if (phase_q != PH_IDLE) begin
			if (spent >= len) begin
				tick_d = '0;
				case (phase_q)
					PH_START_HI: begin
						line_d  = 1'b0;
						phase_d = PH_START_LO;
					end
					PH_START_LO: begin
						line_d  = 1'b1;
						bit_d   = '0;
						phase_d = PH_BIT_HI;
					end
					PH_BIT_HI: begin
						line_d  = 1'b0;
						phase_d = PH_BIT_LO;
					end
					default: begin
						shift_d = shift_q >> 1;
						line_d  = 1'b1;
						if (bit_next >= (BW+1)'(BITS_PER_FRAME)) begin
							bit_d   = '0;
							phase_d = PH_IDLE;
							done_d  = 1'b1;
						end else begin
							bit_d   = bit_next[BW-1:0];
							phase_d = PH_BIT_HI;
						end
					end
				endcase
			end else begin
				tick_d = spent[TW-1:0];
			end
		end
	end

	always_comb begin
		result_d.line_level = line_d;
		result_d.busy_res   = (phase_d != PH_IDLE);
		result_d.rejected   = rejected_d;
		result_d.frame_done = done_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			line_q  <= 1'b1;
		end else if (accept) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			line_q  <= line_d;
		end
	end

	// output beat register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid    <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!res_valid || res_ready) begin
			if (skid_valid_q) begin
				res_valid    <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				res_valid <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!res_valid || res_ready) begin
			if (skid_valid_q) begin
				res <= skid_s1;
			end else if (accept) begin
				res <= result_d;
			end
		end else if (accept) begin
			skid_s1 <= result_d;
		end
	end

endmodule
